/* hw/rtl/egsd_pkg.sv */
// shared types, codes and mapping tables for the exp-golomb syntax decoder
`timescale 1ns / 1ps

package egsd_pkg;

   localparam int WINDOW_W            = 64;
   localparam int WINDOW_BITS_DEFAULT = 64;
   localparam int VALUE_W             = 32;
   localparam int MAX_LEAD_ZEROS      = 32;

   // operation codes
   localparam logic [2:0] OP_READ = 3'd0;
   localparam logic [2:0] OP_PEEK = 3'd1;
   localparam logic [2:0] OP_UE   = 3'd2;
   localparam logic [2:0] OP_SE   = 3'd3;
   localparam logic [2:0] OP_TE   = 3'd4;
   localparam logic [2:0] OP_ME   = 3'd5;

   // error codes
   localparam logic [1:0] ERR_NONE        = 2'd0;
   localparam logic [1:0] ERR_LEAD_ZEROS  = 2'd1;
   localparam logic [1:0] ERR_ME_RANGE    = 2'd2;

   localparam logic [1:0] CHROMA_RESET = 2'd1;
   localparam logic [5:0] FIXED_MAX    = 6'd32;
   localparam int         CBP48_SIZE   = 48;
   localparam int         CBP16_SIZE   = 16;

   typedef struct packed {
      logic [2:0]           operation;
      logic [WINDOW_W-1:0]  bit_window;
      logic [5:0]           bit_count;
      logic [4:0]           te_range;
      logic                 intra_mode;
   } req_word_type;

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic [5:0]         bits_used;
      logic [1:0]         error_code;
   } rsp_word_type;

   // unsigned exp-golomb decode status
   typedef struct packed {
      logic               ok;
      logic [VALUE_W-1:0] code;
      logic [5:0]         len;
   } ue_result_type;

   localparam logic [5:0] CBP48_INTRA [CBP48_SIZE] = '{
      6'd47, 6'd31, 6'd15, 6'd0,  6'd23, 6'd27, 6'd29, 6'd30,
      6'd7,  6'd11, 6'd13, 6'd14, 6'd39, 6'd43, 6'd45, 6'd46,
      6'd16, 6'd3,  6'd5,  6'd10, 6'd12, 6'd19, 6'd21, 6'd26,
      6'd28, 6'd35, 6'd37, 6'd42, 6'd44, 6'd1,  6'd2,  6'd4,
      6'd8,  6'd17, 6'd18, 6'd20, 6'd24, 6'd6,  6'd9,  6'd22,
      6'd25, 6'd32, 6'd33, 6'd34, 6'd36, 6'd40, 6'd38, 6'd41};

   localparam logic [5:0] CBP48_INTER [CBP48_SIZE] = '{
      6'd0,  6'd16, 6'd1,  6'd2,  6'd4,  6'd8,  6'd32, 6'd3,
      6'd5,  6'd10, 6'd12, 6'd15, 6'd47, 6'd7,  6'd11, 6'd13,
      6'd14, 6'd6,  6'd9,  6'd31, 6'd35, 6'd37, 6'd42, 6'd44,
      6'd33, 6'd34, 6'd36, 6'd40, 6'd39, 6'd43, 6'd45, 6'd46,
      6'd17, 6'd18, 6'd20, 6'd24, 6'd19, 6'd21, 6'd26, 6'd28,
      6'd23, 6'd27, 6'd29, 6'd30, 6'd22, 6'd25, 6'd38, 6'd41};

   localparam logic [5:0] CBP16_INTRA [CBP16_SIZE] = '{
      6'd15, 6'd0, 6'd7,  6'd11, 6'd13, 6'd14, 6'd3,  6'd5,
      6'd10, 6'd12, 6'd1, 6'd2,  6'd4,  6'd8,  6'd6,  6'd9};

   localparam logic [5:0] CBP16_INTER [CBP16_SIZE] = '{
      6'd0,  6'd1,  6'd2,  6'd4,  6'd8,  6'd3,  6'd5,  6'd10,
      6'd12, 6'd15, 6'd7,  6'd11, 6'd13, 6'd14, 6'd6,  6'd9};

endpackage

/* hw/rtl/exp_golomb_syntax_decoder_top.sv */
// top level of the exp-golomb syntax decoder: input register, decode, result register
//
//   channel   ports                          handshake
//   request   start, busy, req_word          taken when start && !busy
//   response  rsp_strobe, rsp_word           one-cycle strobe, no back-pressure
//   csr       csr_valid, csr_ready, csr_data written when csr_valid && csr_ready
//
// one word per cycle sustained; a taken word passes the input register, then the
// result register after the decode logic.
// busy is always low: the receiver cannot stall, so nothing backs up.
// reset clears the pipeline valid bits and sets chroma_array_type to 1.
`timescale 1ns / 1ps

module exp_golomb_syntax_decoder_top
   import egsd_pkg::*;
#(
   parameter int WINDOW_BITS = WINDOW_BITS_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_word_type req_word,
   output logic         rsp_strobe,
   output rsp_word_type rsp_word,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [1:0]   csr_data
);

   logic         accept;
   logic         in_valid_ff;
   req_word_type in_word_ff;
   logic [1:0]   chroma_ff;
   logic [1:0]   chroma_in;
   rsp_word_type dec_rsp;
   logic         rsp_strobe_ff;
   rsp_word_type rsp_word_ff;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign accept    = start && !busy;
   assign chroma_in = (csr_valid && csr_ready) ? csr_data : chroma_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         chroma_ff     <= CHROMA_RESET;
      end else begin
         in_valid_ff   <= accept;
         rsp_strobe_ff <= in_valid_ff;
         chroma_ff     <= chroma_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_word_ff <= req_word;
      end
      rsp_word_ff <= dec_rsp;
   end

   egsd_decode #(
      .WINDOW_BITS (WINDOW_BITS)
   ) u_decode (
      .req               (in_word_ff),
      .chroma_array_type (chroma_ff),
      .rsp               (dec_rsp)
   );

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word   = rsp_word_ff;

   // every taken word comes back through the input and result registers
   a_word_returns: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##2 rsp_strobe)
      else $error("taken word produced no result");

   // no result without a taken word behind it
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept, 2))
      else $error("result without a taken word");

   // errors never advance the stream
   a_err_no_advance: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_word.error_code != ERR_NONE) |-> (rsp_word.bits_used == 6'd0))
      else $error("error result advances the stream");

   // table range error only from an me word
   a_me_err_source: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_word.error_code == ERR_ME_RANGE)
         |-> ($past(in_word_ff.operation) == OP_ME))
      else $error("table range error from a non-me word");

   // chroma type comes out of reset at its default
   a_chroma_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> (chroma_ff == CHROMA_RESET))
      else $error("chroma type not at reset value");

endmodule

/* hw/rtl/egsd_ue_decode.sv */
// leading zero count and unsigned exp-golomb code extraction
`timescale 1ns / 1ps

module egsd_ue_decode
   import egsd_pkg::*;
(
   input  logic [WINDOW_W-1:0] window,
   output ue_result_type       ue
);

   logic [5:0]          lead_zeros;
   logic [5:0]          total;
   logic [6:0]          shamt;
   logic [WINDOW_W-1:0] shifted;

   // smallest index of a one in the top 32 bits wins
   always_comb begin
      lead_zeros = 6'(MAX_LEAD_ZEROS);
      for (int i = MAX_LEAD_ZEROS - 1; i >= 0; i--) begin
         if (window[WINDOW_W-1-i]) begin
            lead_zeros = 6'(i);
         end
      end
   end

   assign total   = {lead_zeros[4:0], 1'b1};
   assign shamt   = 7'(WINDOW_W) - {1'b0, total};
   assign shifted = window >> shamt;

   always_comb begin
      ue.ok   = (lead_zeros < 6'(MAX_LEAD_ZEROS));
      ue.code = shifted[VALUE_W-1:0] - 32'd1;
      ue.len  = total;
   end

endmodule

/* hw/rtl/egsd_decode.sv */
// per-operation decode of one syntax element from an aligned window
`timescale 1ns / 1ps

module egsd_decode
   import egsd_pkg::*;
#(
   parameter int WINDOW_BITS = WINDOW_BITS_DEFAULT
) (
   input  req_word_type req,
   input  logic [1:0]   chroma_array_type,
   output rsp_word_type rsp
);

   logic [WINDOW_W-1:0] window;
   ue_result_type       ue;
   logic [5:0]          n_sat;
   logic [VALUE_W-1:0]  fixed_value;
   logic [VALUE_W-1:0]  se_value;
   logic [VALUE_W:0]    code_plus;
   logic                big_table;
   logic                me_in_range;
   logic [5:0]          me_index;
   logic [5:0]          me_value;

   // left-align the window; bits above the window drop out of the shift
   assign window = req.bit_window << (WINDOW_W - WINDOW_BITS);

   egsd_ue_decode u_ue (
      .window (window),
      .ue     (ue)
   );

   assign n_sat       = (req.bit_count > FIXED_MAX) ? FIXED_MAX : req.bit_count;
   // a count of zero shifts everything out
   assign fixed_value = window[WINDOW_W-1 -: VALUE_W] >> (FIXED_MAX - n_sat);

   assign code_plus = {1'b0, ue.code} + 33'd1;
   assign se_value  = ue.code[0] ? code_plus[VALUE_W:1]
                                 : (32'd0 - {1'b0, ue.code[VALUE_W-1:1]});

   assign big_table   = (chroma_array_type == 2'd1) || (chroma_array_type == 2'd2);
   assign me_in_range = big_table ? (ue.code < 32'(CBP48_SIZE))
                                  : (ue.code < 32'(CBP16_SIZE));
   assign me_index    = ue.code[5:0];

   always_comb begin
      me_value = 6'd0;
      if (me_in_range) begin
         if (big_table) begin
            me_value = req.intra_mode ? CBP48_INTRA[me_index] : CBP48_INTER[me_index];
         end else begin
            me_value = req.intra_mode ? CBP16_INTRA[me_index[3:0]]
                                      : CBP16_INTER[me_index[3:0]];
         end
      end
   end

   always_comb begin
      rsp.value      = '0;
      rsp.bits_used  = '0;
      rsp.error_code = ERR_NONE;
      case (req.operation)
         OP_READ: begin
            rsp.value     = fixed_value;
            rsp.bits_used = n_sat;
         end
         OP_PEEK: begin
            rsp.value = fixed_value;
         end
         OP_UE: begin
            if (ue.ok) begin
               rsp.value     = ue.code;
               rsp.bits_used = ue.len;
            end else begin
               rsp.error_code = ERR_LEAD_ZEROS;
            end
         end
         OP_SE: begin
            if (ue.ok) begin
               rsp.value     = se_value;
               rsp.bits_used = ue.len;
            end else begin
               rsp.error_code = ERR_LEAD_ZEROS;
            end
         end
         OP_TE: begin
            if (req.te_range == 5'd1) begin
               rsp.value     = {31'd0, ~window[WINDOW_W-1]};
               rsp.bits_used = 6'd1;
            end else if (req.te_range != 5'd0) begin
               if (ue.ok) begin
                  rsp.value     = ue.code;
                  rsp.bits_used = ue.len;
               end else begin
                  rsp.error_code = ERR_LEAD_ZEROS;
               end
            end
         end
         OP_ME: begin
            if (!ue.ok) begin
               rsp.error_code = ERR_LEAD_ZEROS;
            end else if (me_in_range) begin
               rsp.value     = {26'd0, me_value};
               rsp.bits_used = ue.len;
            end else begin
               rsp.error_code = ERR_ME_RANGE;
            end
         end
         default: begin
            rsp.value = '0;
         end
      endcase
   end

endmodule
